// File: design/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types, codes and helpers for the ring FIFO with peek.
// ----------------------------------------------------------------------------
package rfp_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int CNT_W     = PTR_W + 1;
	localparam int ADDR_W    = CNT_W;      // pointer + offset before wrap
	localparam int PADDR_W   = 3;

	localparam logic [1:0] ACT_ENQ  = 2'd0;
	localparam logic [1:0] ACT_DEQ  = 2'd1;
	localparam logic [1:0] ACT_PEEK = 2'd2;
	localparam logic [1:0] ACT_STOP = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_STOPPED = 3'd3;
	localparam logic [2:0] ST_RANGE   = 3'd4;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

	typedef struct packed {
		logic [1:0]           action;
		logic [WORD_BITS-1:0] write_value;
		logic [3:0]           peek_offset;
	} in_word_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] read_data;
		logic [2:0]           status;
		logic [CNT_W-1:0]     entry_count;
		logic                 is_empty_flag;
		logic                 stopped_flag;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic sub;
		logic rd;
		logic load;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic mod_done;
		logic out_busy;
	} dp_stat_t;

	// increment and wrap at the effective capacity
	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		n = {1'b0, p} + CNT_W'(1);
		return (n >= cap) ? '0 : n[PTR_W-1:0];
	endfunction

endpackage

// File: design/rfp_ctrl.sv
// ----------------------------------------------------------------------------
// rfp_ctrl
// Sequencer: accept, execute, wrap peek address, read, hand off result.
// ----------------------------------------------------------------------------
module rfp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rfp_pkg::dp_stat_t stat,
	output rfp_pkg::dp_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_MOD  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_MOD;
			end
			S_MOD: begin
				if (stat.mod_done) begin
					cmd.rd  = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.sub = 1'b1;
				end
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/rfp_datapath.sv
// ----------------------------------------------------------------------------
// rfp_datapath
// Word store, pointers, count, halt flag, capacity and output register.
// ----------------------------------------------------------------------------
module rfp_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rfp_pkg::in_word_t                 in_data,
	input  rfp_pkg::dp_cmd_t                  cmd,
	output rfp_pkg::dp_stat_t                 stat,
	input  logic                              cfg_we,
	input  logic [rfp_pkg::CNT_W-1:0]         cfg_wdata,
	output logic [rfp_pkg::CNT_W-1:0]         cap_val,
	output logic                              out_valid,
	input  logic                              out_stall,
	output rfp_pkg::out_word_t                out_data
);

	logic [rfp_pkg::WORD_BITS-1:0] mem [rfp_pkg::DEPTH];

	rfp_pkg::in_word_t             item_q;
	rfp_pkg::out_word_t            out_q;
	logic                          out_valid_q;
	logic [rfp_pkg::CNT_W-1:0]     cap_q;
	logic [rfp_pkg::PTR_W-1:0]     rp_q;
	logic [rfp_pkg::PTR_W-1:0]     wp_q;
	logic [rfp_pkg::CNT_W-1:0]     fill_q;
	logic                          halted_q;
	logic [2:0]                    status_q;
	logic                          rd_ok_q;
	logic                          mod_q;
	logic [rfp_pkg::ADDR_W-1:0]    addr_q;
	logic [rfp_pkg::WORD_BITS-1:0] rdata_q;

	logic [rfp_pkg::CNT_W-1:0]     cap_eff;
	logic [2:0]                    st;
	logic                          do_wr;
	logic                          do_deq;
	logic                          do_peek;
	logic                          do_stop;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = rfp_pkg::CNT_W'(1);
		end else if (cap_q > rfp_pkg::CAP_RESET) begin
			cap_eff = rfp_pkg::CAP_RESET;
		end else begin
			cap_eff = cap_q;
		end
	end

	always_comb begin
		st      = rfp_pkg::ST_OK;
		do_wr   = 1'b0;
		do_deq  = 1'b0;
		do_peek = 1'b0;
		do_stop = 1'b0;
		unique case (item_q.action)
			rfp_pkg::ACT_ENQ: begin
				if (halted_q) begin
					st = rfp_pkg::ST_STOPPED;
				end else if (fill_q >= cap_eff) begin
					st = rfp_pkg::ST_FULL;
				end else begin
					do_wr = 1'b1;
				end
			end
			rfp_pkg::ACT_DEQ: begin
				if (fill_q == '0) begin
					st = rfp_pkg::ST_EMPTY;
				end else begin
					do_deq = 1'b1;
				end
			end
			rfp_pkg::ACT_PEEK: begin
				if ({1'b0, item_q.peek_offset} >= fill_q) begin
					st = rfp_pkg::ST_RANGE;
				end else begin
					do_peek = 1'b1;
				end
			end
			default: do_stop = 1'b1;
		endcase
	end

	// peek address wraps by repeated subtraction; dequeue address is used as is
	assign stat.mod_done = !mod_q || (addr_q < cap_eff);
	assign stat.out_busy = out_valid_q && out_stall;

	assign cap_val   = cap_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= rfp_pkg::CAP_RESET;
			rp_q        <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				if (do_wr) begin
					wp_q   <= rfp_pkg::advance(wp_q, cap_eff);
					fill_q <= fill_q + rfp_pkg::CNT_W'(1);
				end
				if (do_deq) begin
					rp_q   <= rfp_pkg::advance(rp_q, cap_eff);
					fill_q <= fill_q - rfp_pkg::CNT_W'(1);
				end
				if (do_stop) begin
					halted_q <= 1'b1;
				end
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
		if (cmd.exec) begin
			status_q <= st;
			rd_ok_q  <= do_deq || do_peek;
			mod_q    <= do_peek;
			if (do_peek) begin
				addr_q <= {1'b0, rp_q} + {1'b0, item_q.peek_offset};
			end else begin
				addr_q <= {1'b0, rp_q};
			end
		end else if (cmd.sub) begin
			addr_q <= addr_q - cap_eff;
		end
		if (cmd.load) begin
			out_q.read_data     <= rd_ok_q ? rdata_q : '0;
			out_q.status        <= status_q;
			out_q.entry_count   <= fill_q;
			out_q.is_empty_flag <= (fill_q == '0);
			out_q.stopped_flag  <= halted_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && do_wr) begin
			mem[wp_q] <= item_q.write_value;
		end
		if (cmd.rd) begin
			rdata_q <= mem[addr_q[rfp_pkg::PTR_W-1:0]];
		end
	end

endmodule

// File: design/ring_fifo_with_peek_core.sv
// ----------------------------------------------------------------------------
// ring_fifo_with_peek_core
// Ring FIFO of 32-bit words with enqueue, dequeue, peek and stop actions.
// ----------------------------------------------------------------------------
// One word in gives one word out. An item passes through accept, execute,
// memory read and result load. A peek whose read pointer plus offset reaches
// the capacity first has the capacity subtracted from its address, again and
// again, until the address is below the capacity. The next word is accepted
// once the previous result has been loaded, and loading waits while an earlier
// result is still stalled at the output. The user must write capacity (register
// at byte address 0) only while the block is idle; the block itself does not
// enforce this.
module ring_fifo_with_peek_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  rfp_pkg::in_word_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output rfp_pkg::out_word_t          out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rfp_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	rfp_pkg::dp_cmd_t           cmd;
	rfp_pkg::dp_stat_t          stat;
	logic                       cfg_we;
	logic [rfp_pkg::CNT_W-1:0]  cap_val;
	logic                       cap_sel;

	assign pready  = 1'b1;
	assign cap_sel = (paddr[rfp_pkg::PADDR_W-1] == 1'b0);
	assign cfg_we  = psel && penable && pwrite && pready && cap_sel;
	assign prdata  = cap_sel ? {{(32 - rfp_pkg::CNT_W){1'b0}}, cap_val} : '0;

	rfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	rfp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata[rfp_pkg::CNT_W-1:0]),
		.cap_val   (cap_val),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// one word in flight: no second accept right after one
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("word accepted while previous one in flight");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.entry_count <= rfp_pkg::CAP_RESET)
		else $error("entry count above depth");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.is_empty_flag == (out_data.entry_count == '0))
		else $error("empty flag disagrees with count");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != rfp_pkg::ST_OK) |-> out_data.read_data == '0)
		else $error("refused action returned data");

endmodule
